// ----- rtl/system_control_coprocessor_regs_top_macros.svh -----
// Assertion macros for the system control coprocessor register block.
// Included by the top level; depends on nothing else.
`ifndef SYSTEM_CONTROL_COPROCESSOR_REGS_TOP_MACROS_SVH
`define SYSTEM_CONTROL_COPROCESSOR_REGS_TOP_MACROS_SVH

`define SCC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scc assertion failed");

`define SCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scc assertion failed");

`endif

// ----- rtl/scc_pkg.sv -----
// Package for the system control coprocessor register block: beat types, selector keys,
// register slots, operation and state codes, and the permission packing functions.
package scc_pkg;

  localparam int NUM_REGIONS = 8;

  typedef struct packed {
    logic        mode;
    logic [2:0]  opc1;
    logic [3:0]  crn;
    logic [3:0]  crm;
    logic [2:0]  opc2;
    logic [31:0] write_data;
  } req_beat_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        halt;
    logic        invalidate_valid;
    logic [31:0] invalidate_start;
    logic [31:0] invalidate_end;
    logic        has_side_effects;
  } rsp_beat_t;

  typedef logic [14:0] key_t;
  typedef logic [3:0]  slot_t;
  typedef logic [2:0]  cfg_index_t;

  localparam key_t KEY_MAIN_ID        = 15'h0000;
  localparam key_t KEY_CACHE_TYPE     = 15'h0001;
  localparam key_t KEY_TCM_SIZE       = 15'h0002;
  localparam key_t KEY_MAIN_ID_ALT_LO = 15'h0003;
  localparam key_t KEY_MAIN_ID_ALT_HI = 15'h0007;
  localparam key_t KEY_CONTROL        = 15'h0100;
  localparam key_t KEY_DCACHE_BITS    = 15'h0200;
  localparam key_t KEY_ICACHE_BITS    = 15'h0201;
  localparam key_t KEY_BUFFER_BITS    = 15'h0300;
  localparam key_t KEY_DPERM_LEGACY   = 15'h0500;
  localparam key_t KEY_IPERM_LEGACY   = 15'h0501;
  localparam key_t KEY_DPERM_EXT      = 15'h0502;
  localparam key_t KEY_IPERM_EXT      = 15'h0503;
  localparam key_t KEY_WFI            = 15'h0704;
  localparam key_t KEY_WFI_ALT        = 15'h0782;
  localparam key_t KEY_ICACHE_INV_ALL = 15'h0750;
  localparam key_t KEY_ICACHE_INV_LN  = 15'h0751;
  localparam key_t KEY_DTCM           = 15'h0910;
  localparam key_t KEY_ITCM           = 15'h0911;

  localparam logic [6:0] KEY_REGION_PREFIX = 7'h06;

  localparam slot_t SLOT_CONTROL = 4'd0;
  localparam slot_t SLOT_DCACHE  = 4'd1;
  localparam slot_t SLOT_ICACHE  = 4'd2;
  localparam slot_t SLOT_BUFFER  = 4'd3;
  localparam slot_t SLOT_DPERM   = 4'd4;
  localparam slot_t SLOT_IPERM   = 4'd5;
  localparam slot_t SLOT_REGION0 = 4'd6;
  localparam slot_t SLOT_DTCM    = 4'd14;
  localparam slot_t SLOT_ITCM    = 4'd15;

  localparam int NUM_SLOTS = 16;

  localparam cfg_index_t CFG_MAIN_ID     = 3'd0;
  localparam cfg_index_t CFG_CACHE_TYPE  = 3'd1;
  localparam cfg_index_t CFG_TCM_SIZE    = 3'd2;
  localparam cfg_index_t CFG_CTL_MASK    = 3'd3;
  localparam cfg_index_t CFG_CTL_ONES    = 3'd4;

  localparam logic [31:0] MAIN_ID_RESET  = 32'h40FF_F940;
  localparam logic [31:0] CTL_MASK_RESET = 32'h000F_F085;
  localparam logic [31:0] CTL_ONES_RESET = 32'h0000_0078;
  localparam logic [31:0] LINE_MASK      = 32'h0000_001F;
  localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_RD_MAIN_ID,
    OP_RD_CACHE_TYPE,
    OP_RD_TCM_SIZE,
    OP_RD_CONTROL,
    OP_RD_RAW,
    OP_RD_PACK,
    OP_WR_CONTROL,
    OP_WR_BYTE,
    OP_WR_SPREAD,
    OP_WR_RAW,
    OP_HALT,
    OP_INV_ALL,
    OP_INV_LINE
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_ACCESS
  } state_t;

  function automatic logic [15:0] pack_perm(logic [31:0] w);
    logic [15:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[2*i +: 2] = w[4*i +: 2];
    end
    return r;
  endfunction

  function automatic logic [31:0] spread_perm(logic [15:0] v);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[4*i +: 2] = v[2*i +: 2];
    end
    return r;
  endfunction

endpackage

// ----- rtl/system_control_coprocessor_regs_top.sv -----
// Top level of the system control coprocessor register block.
// Depends on scc_pkg and on system_control_coprocessor_regs_top_macros.svh.
//
// The request channel (req_valid, req_stall, req) carries one coprocessor access per beat:
// a read or write of the register selected by opc1, crn, crm and opc2. The response channel
// (rsp_valid, rsp_stall, rsp) returns exactly one beat per access, in order. The cfg port
// (cfg_valid, cfg_ready, cfg_index, cfg_data) sets the identification values and the
// control-register mask and fixed ones; it is always ready.
// The stored registers live in a 16-entry memory with a registered read port. An accepted
// access reads its entry at the accept edge. Once the response register is free, the result
// is formed, the entry is written back and the response register is loaded in the same
// cycle. Between acceptance and that write-back req_stall is high, so one access at a time
// goes through the read and write-back of the memory.
// Reset clears the entry valid bits, so every entry reads as its reset value until written,
// and restores the configuration values. While the receiver stalls, the finished response is
// held; one more access may be accepted and waits in its write-back cycle until the response
// register frees, with req_stall high.
`include "system_control_coprocessor_regs_top_macros.svh"

module system_control_coprocessor_regs_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  scc_pkg::req_beat_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output scc_pkg::rsp_beat_t rsp,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  scc_pkg::cfg_index_t cfg_index,
  input  logic [31:0]        cfg_data
);

  scc_pkg::state_t state;
  scc_pkg::state_t state_next;

  logic [31:0] main_id;
  logic [31:0] cache_type;
  logic [31:0] tcm_size;
  logic [31:0] ctl_mask;
  logic [31:0] ctl_ones;

  logic [31:0] mem [scc_pkg::NUM_SLOTS];
  logic [scc_pkg::NUM_SLOTS-1:0] slot_valid;
  logic [31:0] mem_q;
  logic        mem_hit;

  scc_pkg::key_t  req_key;
  logic           region_hit;
  scc_pkg::op_t   dec_op;
  scc_pkg::slot_t dec_slot;
  logic           req_accept;

  scc_pkg::op_t   op;
  scc_pkg::slot_t slot;
  logic [31:0]    wdata;

  logic               finish;
  logic [31:0]        old_value;
  logic               mem_we;
  logic [31:0]        mem_wdata;
  scc_pkg::rsp_beat_t rsp_next;

  assign cfg_ready  = 1'b1;
  assign req_key    = {req.opc1, req.crn, req.crm, 1'b0, req.opc2};
  assign req_accept = req_valid && !req_stall;
  assign region_hit = (req_key[14:8] == scc_pkg::KEY_REGION_PREFIX) && (req.opc2[2:1] == 2'b00)
                      && ({1'b0, req.crm} < 5'(scc_pkg::NUM_REGIONS));

  always_comb begin
    dec_op   = scc_pkg::OP_NONE;
    dec_slot = scc_pkg::SLOT_CONTROL;
    if (!req.mode) begin
      case (req_key) inside
        scc_pkg::KEY_MAIN_ID,
        [scc_pkg::KEY_MAIN_ID_ALT_LO:scc_pkg::KEY_MAIN_ID_ALT_HI]: begin
          dec_op = scc_pkg::OP_RD_MAIN_ID;
        end
        scc_pkg::KEY_CACHE_TYPE: dec_op = scc_pkg::OP_RD_CACHE_TYPE;
        scc_pkg::KEY_TCM_SIZE:   dec_op = scc_pkg::OP_RD_TCM_SIZE;
        scc_pkg::KEY_CONTROL:    dec_op = scc_pkg::OP_RD_CONTROL;
        scc_pkg::KEY_DCACHE_BITS: begin
          dec_op = scc_pkg::OP_RD_RAW; dec_slot = scc_pkg::SLOT_DCACHE;
        end
        scc_pkg::KEY_ICACHE_BITS: begin
          dec_op = scc_pkg::OP_RD_RAW; dec_slot = scc_pkg::SLOT_ICACHE;
        end
        scc_pkg::KEY_BUFFER_BITS: begin
          dec_op = scc_pkg::OP_RD_RAW; dec_slot = scc_pkg::SLOT_BUFFER;
        end
        scc_pkg::KEY_DPERM_LEGACY: begin
          dec_op = scc_pkg::OP_RD_PACK; dec_slot = scc_pkg::SLOT_DPERM;
        end
        scc_pkg::KEY_IPERM_LEGACY: begin
          dec_op = scc_pkg::OP_RD_PACK; dec_slot = scc_pkg::SLOT_IPERM;
        end
        scc_pkg::KEY_DPERM_EXT: begin
          dec_op = scc_pkg::OP_RD_RAW; dec_slot = scc_pkg::SLOT_DPERM;
        end
        scc_pkg::KEY_IPERM_EXT: begin
          dec_op = scc_pkg::OP_RD_RAW; dec_slot = scc_pkg::SLOT_IPERM;
        end
        scc_pkg::KEY_DTCM: begin
          dec_op = scc_pkg::OP_RD_RAW; dec_slot = scc_pkg::SLOT_DTCM;
        end
        scc_pkg::KEY_ITCM: begin
          dec_op = scc_pkg::OP_RD_RAW; dec_slot = scc_pkg::SLOT_ITCM;
        end
        default: begin
          if (region_hit) begin
            dec_op   = scc_pkg::OP_RD_RAW;
            dec_slot = scc_pkg::SLOT_REGION0 + {1'b0, req.crm[2:0]};
          end
        end
      endcase
    end else begin
      case (req_key) inside
        scc_pkg::KEY_CONTROL: dec_op = scc_pkg::OP_WR_CONTROL;
        scc_pkg::KEY_DCACHE_BITS: begin
          dec_op = scc_pkg::OP_WR_BYTE; dec_slot = scc_pkg::SLOT_DCACHE;
        end
        scc_pkg::KEY_ICACHE_BITS: begin
          dec_op = scc_pkg::OP_WR_BYTE; dec_slot = scc_pkg::SLOT_ICACHE;
        end
        scc_pkg::KEY_BUFFER_BITS: begin
          dec_op = scc_pkg::OP_WR_BYTE; dec_slot = scc_pkg::SLOT_BUFFER;
        end
        scc_pkg::KEY_DPERM_LEGACY: begin
          dec_op = scc_pkg::OP_WR_SPREAD; dec_slot = scc_pkg::SLOT_DPERM;
        end
        scc_pkg::KEY_IPERM_LEGACY: begin
          dec_op = scc_pkg::OP_WR_SPREAD; dec_slot = scc_pkg::SLOT_IPERM;
        end
        scc_pkg::KEY_DPERM_EXT: begin
          dec_op = scc_pkg::OP_WR_RAW; dec_slot = scc_pkg::SLOT_DPERM;
        end
        scc_pkg::KEY_IPERM_EXT: begin
          dec_op = scc_pkg::OP_WR_RAW; dec_slot = scc_pkg::SLOT_IPERM;
        end
        scc_pkg::KEY_DTCM: begin
          dec_op = scc_pkg::OP_WR_RAW; dec_slot = scc_pkg::SLOT_DTCM;
        end
        scc_pkg::KEY_ITCM: begin
          dec_op = scc_pkg::OP_WR_RAW; dec_slot = scc_pkg::SLOT_ITCM;
        end
        scc_pkg::KEY_WFI, scc_pkg::KEY_WFI_ALT: dec_op = scc_pkg::OP_HALT;
        scc_pkg::KEY_ICACHE_INV_ALL: dec_op = scc_pkg::OP_INV_ALL;
        scc_pkg::KEY_ICACHE_INV_LN:  dec_op = scc_pkg::OP_INV_LINE;
        default: begin
          if (region_hit) begin
            dec_op   = scc_pkg::OP_WR_RAW;
            dec_slot = scc_pkg::SLOT_REGION0 + {1'b0, req.crm[2:0]};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_id    <= scc_pkg::MAIN_ID_RESET;
      cache_type <= '0;
      tcm_size   <= '0;
      ctl_mask   <= scc_pkg::CTL_MASK_RESET;
      ctl_ones   <= scc_pkg::CTL_ONES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        scc_pkg::CFG_MAIN_ID:    main_id    <= cfg_data;
        scc_pkg::CFG_CACHE_TYPE: cache_type <= cfg_data;
        scc_pkg::CFG_TCM_SIZE:   tcm_size   <= cfg_data;
        scc_pkg::CFG_CTL_MASK:   ctl_mask   <= cfg_data;
        scc_pkg::CFG_CTL_ONES:   ctl_ones   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      op      <= dec_op;
      slot    <= dec_slot;
      wdata   <= req.write_data;
      mem_q   <= mem[dec_slot];
      mem_hit <= slot_valid[dec_slot];
    end
    if (mem_we) begin
      mem[slot] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (mem_we) begin
      slot_valid[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    finish     = 1'b0;
    case (state)
      scc_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          state_next = scc_pkg::ST_ACCESS;
        end
      end
      scc_pkg::ST_ACCESS: begin
        if (!rsp_valid || !rsp_stall) begin
          finish     = 1'b1;
          state_next = scc_pkg::ST_IDLE;
        end
      end
      default: state_next = scc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    old_value = mem_hit ? mem_q
              : ((slot == scc_pkg::SLOT_CONTROL) ? scc_pkg::CTL_ONES_RESET : '0);
    mem_we    = 1'b0;
    mem_wdata = wdata;
    rsp_next  = '0;
    case (op)
      scc_pkg::OP_RD_MAIN_ID:    rsp_next.read_data = main_id;
      scc_pkg::OP_RD_CACHE_TYPE: rsp_next.read_data = cache_type;
      scc_pkg::OP_RD_TCM_SIZE:   rsp_next.read_data = tcm_size;
      scc_pkg::OP_RD_CONTROL:    rsp_next.read_data = old_value | ctl_ones;
      scc_pkg::OP_RD_RAW:        rsp_next.read_data = old_value;
      scc_pkg::OP_RD_PACK:       rsp_next.read_data = {16'b0, scc_pkg::pack_perm(old_value)};
      scc_pkg::OP_WR_CONTROL: begin
        mem_we    = finish;
        mem_wdata = (old_value & ~ctl_mask) | (wdata & ctl_mask) | ctl_ones;
      end
      scc_pkg::OP_WR_BYTE: begin
        mem_we    = finish;
        mem_wdata = {24'b0, wdata[7:0]};
      end
      scc_pkg::OP_WR_SPREAD: begin
        mem_we    = finish;
        mem_wdata = scc_pkg::spread_perm(wdata[15:0]);
      end
      scc_pkg::OP_WR_RAW: mem_we = finish;
      scc_pkg::OP_HALT: begin
        rsp_next.halt             = 1'b1;
        rsp_next.has_side_effects = 1'b1;
      end
      scc_pkg::OP_INV_ALL: begin
        rsp_next.invalidate_valid = 1'b1;
        rsp_next.invalidate_end   = scc_pkg::ALL_ONES;
        rsp_next.has_side_effects = 1'b1;
      end
      scc_pkg::OP_INV_LINE: begin
        rsp_next.invalidate_valid = 1'b1;
        rsp_next.invalidate_start = wdata & ~scc_pkg::LINE_MASK;
        rsp_next.invalidate_end   = wdata | scc_pkg::LINE_MASK;
        rsp_next.has_side_effects = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp <= rsp_next;
    end
  end

  `SCC_ASSERT_SAME(a_halt_has_side_effects, clk, rst, rsp_valid && rsp.halt, rsp.has_side_effects)
  `SCC_ASSERT_SAME(a_inv_reads_zero, clk, rst, rsp_valid && rsp.invalidate_valid, rsp.read_data == '0)
  `SCC_ASSERT_NEXT(a_one_access_at_a_time, clk, rst, req_accept, req_stall)
  `SCC_ASSERT_SAME(a_no_read_during_writeback, clk, rst, mem_we, !req_accept)

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for system_control_coprocessor_regs_top.
// Needs scc_pkg; drives coprocessor accesses and configuration writes and predicts
// every response beat from a shadow copy of the registers, unless a directed row gives it.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    scc_pkg::req_beat_t access;
    bit                 typed;
    scc_pkg::rsp_beat_t want;
  } row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  scc_pkg::req_beat_t  req = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  scc_pkg::rsp_beat_t  rsp;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  scc_pkg::cfg_index_t cfg_index = scc_pkg::CFG_MAIN_ID;
  logic [31:0]         cfg_data = '0;

  system_control_coprocessor_regs_top DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [31:0] id_value, cache_type_value, tcm_size_value, ctl_mask, ctl_ones;
  logic [31:0] ctl_reg, dperm_word, iperm_word, dtcm_word, itcm_word;
  logic [7:0]  dcache_bits, icache_bits, buffer_bits;
  logic [31:0] region_mem [scc_pkg::NUM_REGIONS];

  scc_pkg::rsp_beat_t awaited_results [$];
  row_t               directed_rows [$];

  int errors = 0;
  int accepted = 0;
  int writes = 0;
  int checked = 0;
  int halts = 0;
  int invalidates = 0;
  int settings_applied = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int holds_wanted = 0;
  int holds_done = 0;
  int hold_left = 0;

  scc_pkg::key_t known_keys [19] = '{scc_pkg::KEY_MAIN_ID, scc_pkg::KEY_CACHE_TYPE,
                                     scc_pkg::KEY_TCM_SIZE, scc_pkg::KEY_MAIN_ID_ALT_LO,
                                     scc_pkg::KEY_MAIN_ID_ALT_HI, scc_pkg::KEY_CONTROL,
                                     scc_pkg::KEY_DCACHE_BITS, scc_pkg::KEY_ICACHE_BITS,
                                     scc_pkg::KEY_BUFFER_BITS, scc_pkg::KEY_DPERM_LEGACY,
                                     scc_pkg::KEY_IPERM_LEGACY, scc_pkg::KEY_DPERM_EXT,
                                     scc_pkg::KEY_IPERM_EXT, scc_pkg::KEY_WFI,
                                     scc_pkg::KEY_WFI_ALT, scc_pkg::KEY_ICACHE_INV_ALL,
                                     scc_pkg::KEY_ICACHE_INV_LN, scc_pkg::KEY_DTCM,
                                     scc_pkg::KEY_ITCM};

  always #10 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [31:0] gather_perm(logic [31:0] w);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[2*i +: 2] = w[4*i +: 2];
    end
    return r;
  endfunction

  function automatic logic [31:0] scatter_perm(logic [31:0] v);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[4*i +: 2] = v[2*i +: 2];
    end
    return r;
  endfunction

  function automatic scc_pkg::rsp_beat_t predict_access(scc_pkg::req_beat_t a);
    scc_pkg::rsp_beat_t r;
    scc_pkg::key_t      k;
    logic [31:0]        d;
    bit                 region_hit;
    r = '0;
    k = {a.opc1, a.crn, a.crm, 1'b0, a.opc2};
    d = a.write_data;
    region_hit = (k[14:8] == scc_pkg::KEY_REGION_PREFIX) && (a.opc2 <= 3'd1)
                 && (a.crm < scc_pkg::NUM_REGIONS);
    if (!a.mode) begin
      if (k == scc_pkg::KEY_MAIN_ID ||
          (k >= scc_pkg::KEY_MAIN_ID_ALT_LO && k <= scc_pkg::KEY_MAIN_ID_ALT_HI)) begin
        r.read_data = id_value;
      end else if (region_hit) begin
        r.read_data = region_mem[a.crm];
      end else begin
        case (k)
          scc_pkg::KEY_CACHE_TYPE:   r.read_data = cache_type_value;
          scc_pkg::KEY_TCM_SIZE:     r.read_data = tcm_size_value;
          scc_pkg::KEY_CONTROL:      r.read_data = ctl_reg | ctl_ones;
          scc_pkg::KEY_DCACHE_BITS:  r.read_data = {24'd0, dcache_bits};
          scc_pkg::KEY_ICACHE_BITS:  r.read_data = {24'd0, icache_bits};
          scc_pkg::KEY_BUFFER_BITS:  r.read_data = {24'd0, buffer_bits};
          scc_pkg::KEY_DPERM_LEGACY: r.read_data = gather_perm(dperm_word);
          scc_pkg::KEY_IPERM_LEGACY: r.read_data = gather_perm(iperm_word);
          scc_pkg::KEY_DPERM_EXT:    r.read_data = dperm_word;
          scc_pkg::KEY_IPERM_EXT:    r.read_data = iperm_word;
          scc_pkg::KEY_DTCM:         r.read_data = dtcm_word;
          scc_pkg::KEY_ITCM:         r.read_data = itcm_word;
          default:                   r.read_data = '0;
        endcase
      end
    end else begin
      case (k)
        scc_pkg::KEY_WFI, scc_pkg::KEY_WFI_ALT: begin
          r.halt = 1'b1;
          r.has_side_effects = 1'b1;
        end
        scc_pkg::KEY_ICACHE_INV_ALL: begin
          r.invalidate_valid = 1'b1;
          r.invalidate_end = scc_pkg::ALL_ONES;
          r.has_side_effects = 1'b1;
        end
        scc_pkg::KEY_ICACHE_INV_LN: begin
          r.invalidate_valid = 1'b1;
          r.invalidate_start = d & ~scc_pkg::LINE_MASK;
          r.invalidate_end = (d & ~scc_pkg::LINE_MASK) + scc_pkg::LINE_MASK;
          r.has_side_effects = 1'b1;
        end
        scc_pkg::KEY_CONTROL:      ctl_reg = (ctl_reg & ~ctl_mask) | (d & ctl_mask) | ctl_ones;
        scc_pkg::KEY_DCACHE_BITS:  dcache_bits = d[7:0];
        scc_pkg::KEY_ICACHE_BITS:  icache_bits = d[7:0];
        scc_pkg::KEY_BUFFER_BITS:  buffer_bits = d[7:0];
        scc_pkg::KEY_DPERM_LEGACY: dperm_word = scatter_perm(d);
        scc_pkg::KEY_IPERM_LEGACY: iperm_word = scatter_perm(d);
        scc_pkg::KEY_DPERM_EXT:    dperm_word = d;
        scc_pkg::KEY_IPERM_EXT:    iperm_word = d;
        scc_pkg::KEY_DTCM:         dtcm_word = d;
        scc_pkg::KEY_ITCM:         itcm_word = d;
        default: begin
          if (region_hit) region_mem[a.crm] = d;
        end
      endcase
    end
    return r;
  endfunction

  function automatic scc_pkg::req_beat_t access_beat(bit mode, scc_pkg::key_t k,
                                                     logic [31:0] d);
    scc_pkg::req_beat_t b;
    b.mode = mode;
    b.opc1 = k[14:12];
    b.crn = k[11:8];
    b.crm = k[7:4];
    b.opc2 = k[2:0];
    b.write_data = d;
    return b;
  endfunction

  function automatic scc_pkg::rsp_beat_t outcome(logic [31:0] rd, bit halt, bit inv,
                                                 logic [31:0] first, logic [31:0] last,
                                                 bit side);
    scc_pkg::rsp_beat_t r;
    r.read_data = rd;
    r.halt = halt;
    r.invalidate_valid = inv;
    r.invalidate_start = first;
    r.invalidate_end = last;
    r.has_side_effects = side;
    return r;
  endfunction

  function automatic void add_row(bit mode, scc_pkg::key_t k, logic [31:0] d,
                                  bit typed = 1'b0, scc_pkg::rsp_beat_t want = '0);
    row_t row;
    row.access = access_beat(mode, k, d);
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  function automatic row_t random_row();
    row_t          row;
    scc_pkg::key_t k;
    logic [3:0]    region_pick;
    logic [2:0]    sub_pick;
    logic [31:0]   d;
    int            pick;
    pick = $urandom_range(99);
    region_pick = 4'($urandom_range(0, 9));
    sub_pick = 3'($urandom_range(0, 2));
    if (pick < 15) begin
      k = 15'($urandom);
    end else if (pick < 35) begin
      k = {scc_pkg::KEY_REGION_PREFIX, region_pick, 1'b0, sub_pick};
    end else begin
      k = known_keys[$urandom_range(18)];
    end
    case ($urandom_range(9))
      0:       d = '0;
      1:       d = scc_pkg::ALL_ONES;
      default: d = $urandom;
    endcase
    row.access = access_beat(1'($urandom_range(1)), k, d);
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic send_access(row_t row);
    scc_pkg::rsp_beat_t want;
    logic [63:0]        noise;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      noise = {$urandom, $urandom};
      req_valid <= 1'b0;
      req <= noise[$bits(scc_pkg::req_beat_t)-1:0];
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= row.access;
    do @(posedge clk); while (req_stall);
    want = predict_access(row.access);
    if (row.typed) want = row.want;
    awaited_results.push_back(want);
    accepted++;
    if (row.access.mode) writes++;
  endtask

  task automatic cfg_beat(scc_pkg::cfg_index_t idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      scc_pkg::CFG_MAIN_ID:    id_value = v;
      scc_pkg::CFG_CACHE_TYPE: cache_type_value = v;
      scc_pkg::CFG_TCM_SIZE:   tcm_size_value = v;
      scc_pkg::CFG_CTL_MASK:   ctl_mask = v;
      scc_pkg::CFG_CTL_ONES:   ctl_ones = v;
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [31:0] id, logic [31:0] ctype, logic [31:0] tsize,
                                logic [31:0] mask, logic [31:0] ones);
    cfg_beat(scc_pkg::CFG_MAIN_ID, id);
    cfg_beat(scc_pkg::CFG_CACHE_TYPE, ctype);
    cfg_beat(scc_pkg::CFG_TCM_SIZE, tsize);
    cfg_beat(scc_pkg::CFG_CTL_MASK, mask);
    cfg_beat(scc_pkg::CFG_CTL_ONES, ones);
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  task automatic wait_for_results();
    int n;
    n = 0;
    while (awaited_results.size() != 0 && n < 5000) begin
      @(posedge clk);
      n++;
    end
    if (awaited_results.size() != 0) begin
      report_mismatch("results never arrived", awaited_results.size(), '0);
      awaited_results.delete();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done < holds_wanted) begin
      rsp_stall <= 1'b1;
      hold_left <= 63;
      holds_done <= holds_done + 1;
    end else begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    scc_pkg::rsp_beat_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("response beat with nothing awaited", rsp.read_data, '0);
      end else begin
        want = awaited_results.pop_front();
        checked++;
        if (rsp.halt) halts++;
        if (rsp.invalidate_valid) invalidates++;
        if (rsp.read_data !== want.read_data)
          report_mismatch("read_data", rsp.read_data, want.read_data);
        if (rsp.halt !== want.halt)
          report_mismatch("halt", {31'b0, rsp.halt}, {31'b0, want.halt});
        if (rsp.invalidate_valid !== want.invalidate_valid)
          report_mismatch("invalidate_valid", {31'b0, rsp.invalidate_valid},
                          {31'b0, want.invalidate_valid});
        if (rsp.invalidate_start !== want.invalidate_start)
          report_mismatch("invalidate_start", rsp.invalidate_start, want.invalidate_start);
        if (rsp.invalidate_end !== want.invalidate_end)
          report_mismatch("invalidate_end", rsp.invalidate_end, want.invalidate_end);
        if (rsp.has_side_effects !== want.has_side_effects)
          report_mismatch("has_side_effects", {31'b0, rsp.has_side_effects},
                          {31'b0, want.has_side_effects});
      end
    end
  end

  initial begin
    scc_pkg::rsp_beat_t quiet;
    quiet = '0;
    id_value = scc_pkg::MAIN_ID_RESET;
    cache_type_value = '0;
    tcm_size_value = '0;
    ctl_mask = scc_pkg::CTL_MASK_RESET;
    ctl_ones = scc_pkg::CTL_ONES_RESET;
    ctl_reg = scc_pkg::CTL_ONES_RESET;
    dcache_bits = '0;
    icache_bits = '0;
    buffer_bits = '0;
    dperm_word = '0;
    iperm_word = '0;
    dtcm_word = '0;
    itcm_word = '0;
    foreach (region_mem[i]) region_mem[i] = '0;

    // Identification and control reads right after reset, then the control, data-cache bits,
    // permission and region groups, the action keys, and the selectors that must be ignored.
    add_row(1'b0, scc_pkg::KEY_MAIN_ID, scc_pkg::ALL_ONES, 1'b1,
            outcome(scc_pkg::MAIN_ID_RESET, 1'b0, 1'b0, '0, '0, 1'b0));
    add_row(1'b0, scc_pkg::KEY_CACHE_TYPE, '0, 1'b1, quiet);
    add_row(1'b0, scc_pkg::KEY_TCM_SIZE, '0, 1'b1, quiet);
    add_row(1'b0, scc_pkg::KEY_MAIN_ID_ALT_HI, '0, 1'b1,
            outcome(scc_pkg::MAIN_ID_RESET, 1'b0, 1'b0, '0, '0, 1'b0));
    add_row(1'b0, scc_pkg::KEY_CONTROL, '0, 1'b1,
            outcome(scc_pkg::CTL_ONES_RESET, 1'b0, 1'b0, '0, '0, 1'b0));
    add_row(1'b1, scc_pkg::KEY_CONTROL, scc_pkg::ALL_ONES, 1'b1, quiet);
    add_row(1'b0, scc_pkg::KEY_CONTROL, '0);
    add_row(1'b1, scc_pkg::KEY_DCACHE_BITS, scc_pkg::ALL_ONES);
    add_row(1'b0, scc_pkg::KEY_DCACHE_BITS, '0);
    add_row(1'b1, scc_pkg::KEY_DPERM_LEGACY, scc_pkg::ALL_ONES);
    add_row(1'b0, scc_pkg::KEY_DPERM_EXT, '0);
    add_row(1'b0, scc_pkg::KEY_DPERM_LEGACY, '0);
    add_row(1'b1, scc_pkg::KEY_IPERM_EXT, 32'hA5A5_A5A5);
    add_row(1'b0, scc_pkg::KEY_IPERM_LEGACY, '0);
    add_row(1'b1, {scc_pkg::KEY_REGION_PREFIX, 4'd7, 1'b0, 3'd1}, scc_pkg::ALL_ONES);
    add_row(1'b0, {scc_pkg::KEY_REGION_PREFIX, 4'd7, 1'b0, 3'd0}, '0);
    add_row(1'b1, {scc_pkg::KEY_REGION_PREFIX, 4'd8, 1'b0, 3'd0}, scc_pkg::ALL_ONES, 1'b1,
            quiet);
    add_row(1'b0, {scc_pkg::KEY_REGION_PREFIX, 4'd8, 1'b0, 3'd1}, '0, 1'b1, quiet);
    add_row(1'b1, scc_pkg::KEY_WFI, scc_pkg::ALL_ONES, 1'b1,
            outcome('0, 1'b1, 1'b0, '0, '0, 1'b1));
    add_row(1'b1, scc_pkg::KEY_WFI_ALT, '0, 1'b1, outcome('0, 1'b1, 1'b0, '0, '0, 1'b1));
    add_row(1'b1, scc_pkg::KEY_ICACHE_INV_ALL, '0, 1'b1,
            outcome('0, 1'b0, 1'b1, '0, scc_pkg::ALL_ONES, 1'b1));
    add_row(1'b1, scc_pkg::KEY_ICACHE_INV_LN, scc_pkg::ALL_ONES, 1'b1,
            outcome('0, 1'b0, 1'b1, 32'hFFFF_FFE0, scc_pkg::ALL_ONES, 1'b1));
    add_row(1'b1, scc_pkg::KEY_ICACHE_INV_LN, '0, 1'b1,
            outcome('0, 1'b0, 1'b1, '0, scc_pkg::LINE_MASK, 1'b1));
    add_row(1'b0, scc_pkg::KEY_WFI, '0, 1'b1, quiet);
    add_row(1'b1, scc_pkg::KEY_MAIN_ID, '0, 1'b1, quiet);
    add_row(1'b0, scc_pkg::KEY_MAIN_ID, '0, 1'b1,
            outcome(scc_pkg::MAIN_ID_RESET, 1'b0, 1'b0, '0, '0, 1'b0));
    add_row(1'b0, '1, scc_pkg::ALL_ONES, 1'b1, quiet);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    gap_pct = 20;
    stall_pct = 20;
    foreach (directed_rows[i]) send_access(directed_rows[i]);

    for (int phase = 0; phase < 5; phase++) begin
      req_valid <= 1'b0;
      wait_for_results();
      case (phase)
        0: begin
          apply_settings('0, '0, '0, '0, '0);
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          apply_settings(scc_pkg::ALL_ONES, scc_pkg::ALL_ONES, scc_pkg::ALL_ONES,
                         scc_pkg::ALL_ONES, scc_pkg::ALL_ONES);
          gap_pct = 20;
          stall_pct = 20;
        end
        2: begin
          apply_settings(scc_pkg::MAIN_ID_RESET, '0, '0, scc_pkg::CTL_MASK_RESET,
                         scc_pkg::CTL_ONES_RESET);
          gap_pct = 0;
          holds_wanted++;
        end
        default: begin
          apply_settings($urandom, $urandom, $urandom, $urandom, $urandom & $urandom);
          gap_pct = 20;
          stall_pct = 20;
        end
      endcase
      repeat (100) send_access(random_row());
    end
    req_valid <= 1'b0;
    wait_for_results();
    repeat (4) @(posedge clk);

    $display("Ran %0d accesses (%0d writes) across %0d configuration settings.",
             accepted, writes, settings_applied);
    $display("Compared %0d results, with %0d halt requests and %0d invalidate ranges.",
             checked, halts, invalidates);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
